// File: sv/spq_pkg.sv
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int DEPTH     = 64;
	localparam int KEY_BITS  = 16;
	localparam int PRIO_BITS = 16;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int LVL       = $clog2(DEPTH);

	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CHANGE = 2'd1,
		OP_POP    = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		key_t  key;
		prio_t prio;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic  compare;
		logic  insert;
		logic  remove;
		key_t  key;
		prio_t prio;
	} cell_ctl_t;

	// command for the prefix scan
	typedef struct packed {
		logic fill;
		logic scan;
	} scan_ctl_t;

endpackage
`default_nettype wire

// File: sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: command sequencer, cell row,
// prefix scan and result register. Depends on spq_pkg, spq_cell, spq_scan.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | op, key, new_priority
//  output  | out_valid / out_ready| status, found, result_key, result_priority,
//          |                      | head_key, head_priority, entry_count
//
// Steps after acceptance: pop goes straight to the shift step; insert compares
// and shifts; query and a missed change compare, scan and reach the shift step;
// a change that hits compares, scans, shifts left, compares and shifts right.
// The queue is idle again as the result is raised. The cell row shifts all
// entries at once; the prefix scan over the match flags is a registered step
// of its own. A new word is taken while a result waits; the shift stage holds
// until the result register is free. Reset clears the count and control only.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     op,
	input  wire spq_pkg::key_t  key,
	input  wire spq_pkg::prio_t new_priority,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          status,
	output logic                found,
	output spq_pkg::key_t       result_key,
	output spq_pkg::prio_t      result_priority,
	output spq_pkg::key_t       head_key,
	output spq_pkg::prio_t      head_priority,
	output spq_pkg::cnt_t       entry_count
);

	localparam int D = spq_pkg::DEPTH;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_PFX, S_APPLY} state_t;

	state_t              state_q;
	spq_pkg::op_t        op_q;
	spq_pkg::key_t       key_q;
	spq_pkg::prio_t      prio_q;
	spq_pkg::cnt_t       count_q;
	logic                phase2_q;

	logic                out_valid_q;
	spq_pkg::status_t    status_q;
	logic                found_q;
	spq_pkg::key_t       rkey_q;
	spq_pkg::prio_t      rprio_q;
	spq_pkg::key_t       hkey_q;
	spq_pkg::prio_t      hprio_q;
	spq_pkg::cnt_t       cnt_out_q;

	spq_pkg::cell_ctl_t  cell_ctl;
	spq_pkg::scan_ctl_t  scan_ctl;
	spq_pkg::entry_t     ent [D];
	logic [D-1:0]        after_v;
	logic [D-1:0]        match_v;
	logic [D-1:0]        valid_v;
	logic [D-1:0]        pre_v;
	logic [D-1:0]        first_v;

	logic                accept;
	logic                apply_go;
	logic                is_ins;
	logic                any_hit;
	logic                do_ins;
	logic                do_rem;
	logic                emit;
	spq_pkg::prio_t      sel_prio;
	spq_pkg::cnt_t       count_d;
	spq_pkg::status_t    status_d;
	logic                found_d;
	spq_pkg::key_t       rkey_d;
	spq_pkg::prio_t      rprio_d;
	spq_pkg::entry_t     head_d;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign apply_go = (state_q == S_APPLY) && (!out_valid_q || out_ready);
	assign is_ins   = (op_q == spq_pkg::OP_INSERT) || phase2_q;
	assign any_hit  = pre_v[D-1];

	assign do_ins = apply_go && is_ins && (count_q < spq_pkg::CNT_BITS'(D));
	assign do_rem = apply_go && (((op_q == spq_pkg::OP_POP) && (count_q != '0)) ||
		((op_q == spq_pkg::OP_CHANGE) && !phase2_q && any_hit));
	assign emit   = apply_go && !((op_q == spq_pkg::OP_CHANGE) && !phase2_q && any_hit);

	// drive cell and scan commands
	always_comb begin
		cell_ctl.compare = (state_q == S_CMP);
		cell_ctl.insert  = do_ins;
		cell_ctl.remove  = do_rem;
		cell_ctl.key     = key_q;
		cell_ctl.prio    = prio_q;
		scan_ctl.fill    = accept && (spq_pkg::op_t'(op) == spq_pkg::OP_POP);
		scan_ctl.scan    = (state_q == S_PFX);
	end

	// row of cells, each fed by both neighbours
	for (genvar i = 0; i < D; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_a;

		assign valid_v[i] = spq_pkg::CNT_BITS'(i) < count_q;
		assign left_e     = (i == 0) ? ent[0] : ent[(i == 0) ? 0 : i-1];
		assign left_a     = (i == 0) ? 1'b0 : after_v[(i == 0) ? 0 : i-1];
		assign right_e    = (i == D-1) ? ent[D-1] : ent[(i == D-1) ? D-1 : i+1];

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.valid      (valid_v[i]),
			.pre        (pre_v[i]),
			.left_ent   (left_e),
			.left_after (left_a),
			.right_ent  (right_e),
			.ent        (ent[i]),
			.after      (after_v[i]),
			.match      (match_v[i])
		);
	end

	spq_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.match  (match_v),
		.pre    (pre_v),
		.first  (first_v)
	);

	// pick the priority of the first matching cell
	always_comb begin
		sel_prio = '0;
		for (int i = 0; i < D; i++) begin
			sel_prio = sel_prio | ({spq_pkg::PRIO_BITS{first_v[i]}} & ent[i].prio);
		end
	end

	// form the result and the head after this step
	always_comb begin
		status_d = spq_pkg::ST_OK;
		found_d  = 1'b0;
		rkey_d   = key_q;
		rprio_d  = '0;
		count_d  = count_q;
		head_d   = (count_q != '0) ? ent[0] : '0;
		if (is_ins) begin
			found_d = phase2_q;
			if (count_q < spq_pkg::CNT_BITS'(D)) begin
				count_d = count_q + 1'b1;
				head_d  = after_v[0] ? {key_q, prio_q} : ent[0];
			end else begin
				status_d = spq_pkg::ST_FULL;
			end
		end else begin
			case (op_q)
				spq_pkg::OP_POP: begin
					if (count_q == '0) begin
						status_d = spq_pkg::ST_EMPTY;
					end else begin
						rkey_d  = ent[0].key;
						rprio_d = ent[0].prio;
						count_d = count_q - 1'b1;
						head_d  = (count_q > spq_pkg::CNT_BITS'(1)) ? ent[1] : '0;
					end
				end
				spq_pkg::OP_QUERY: begin
					found_d = any_hit;
					rprio_d = any_hit ? sel_prio : spq_pkg::PRIO_BITS'(count_q);
				end
				default: begin
					status_d = spq_pkg::ST_NOT_FOUND;
				end
			endcase
		end
	end

	// sequence the steps, hold the count and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= spq_pkg::OP_INSERT;
			phase2_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= spq_pkg::op_t'(op);
						phase2_q <= 1'b0;
						state_q  <= (spq_pkg::op_t'(op) == spq_pkg::OP_POP) ? S_APPLY : S_CMP;
					end
				end
				S_CMP: begin
					state_q <= is_ins ? S_APPLY : S_PFX;
				end
				S_PFX: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) begin
						if (emit) begin
							state_q <= S_IDLE;
							count_q <= count_d;
						end else begin
							// change found: entry dropped, now place it again
							state_q  <= S_CMP;
							phase2_q <= 1'b1;
							count_q  <= count_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// raise the result flag on a new word, drop it once taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// latch the incoming word and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key;
			prio_q <= new_priority;
		end
		if (emit) begin
			status_q  <= status_d;
			found_q   <= found_d;
			rkey_q    <= rkey_d;
			rprio_q   <= rprio_d;
			hkey_q    <= head_d.key;
			hprio_q   <= head_d.prio;
			cnt_out_q <= count_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign found           = found_q;
	assign result_key      = rkey_q;
	assign result_priority = rprio_q;
	assign head_key        = hkey_q;
	assign head_priority   = hprio_q;
	assign entry_count     = cnt_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_BITS'(D))
		else $error("entry count above depth");

	a_ins_rem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cell_ctl.insert && cell_ctl.remove))
		else $error("insert and remove in the same cycle");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.insert |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not raise the count");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.remove |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not lower the count");

	a_out_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_APPLY))
		else $error("result raised outside the shift step");

endmodule
`default_nettype wire

// File: sv/spq_cell.sv
// One storage cell of the sorted array: holds an entry, its compare flags,
// and shifts to or from its neighbours. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire logic              valid,
	input  wire logic              pre,
	input  wire spq_pkg::entry_t   left_ent,
	input  wire logic              left_after,
	input  wire spq_pkg::entry_t   right_ent,
	output spq_pkg::entry_t        ent,
	output logic                   after,
	output logic                   match
);

	spq_pkg::entry_t ent_q;
	logic            after_q;
	logic            match_q;
	logic            after_d;

	// entry orders strictly after the command's entry; empty cells always do
	always_comb begin
		if (!valid) begin
			after_d = 1'b1;
		end else if (ent_q.prio != ctl.prio) begin
			after_d = ent_q.prio > ctl.prio;
		end else begin
			after_d = ent_q.key > ctl.key;
		end
	end

	// latch compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q <= 1'b0;
			match_q <= 1'b0;
		end else if (ctl.compare) begin
			after_q <= after_d;
			match_q <= valid && (ent_q.key == ctl.key);
		end
	end

	// shift right on insert, shift left from the removal point onward
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_after) begin
				ent_q <= left_ent;
			end else if (after_q) begin
				ent_q.key  <= ctl.key;
				ent_q.prio <= ctl.prio;
			end
		end else if (ctl.remove && pre) begin
			ent_q <= right_ent;
		end
	end

	assign ent   = ent_q;
	assign after = after_q;
	assign match = match_q;

endmodule
`default_nettype wire

// File: sv/spq_scan.sv
// Registered prefix OR over the per-cell match flags, giving for each cell
// whether a match lies at or before it. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire spq_pkg::scan_ctl_t        ctl,
	input  wire logic [spq_pkg::DEPTH-1:0] match,
	output logic      [spq_pkg::DEPTH-1:0] pre,
	output logic      [spq_pkg::DEPTH-1:0] first
);

	logic [spq_pkg::DEPTH-1:0] pre_q;
	logic [spq_pkg::DEPTH-1:0] lvl [spq_pkg::LVL+1];

	// log-depth prefix OR, one doubling span per level
	always_comb begin
		lvl[0] = match;
		for (int l = 0; l < spq_pkg::LVL; l++) begin
			lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
		end
	end

	// hold result; fill marks every cell for removal from the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
		end else if (ctl.fill) begin
			pre_q <= '1;
		end else if (ctl.scan) begin
			pre_q <= lvl[spq_pkg::LVL];
		end
	end

	assign pre   = pre_q;
	assign first = pre_q & ~(pre_q << 1);

endmodule
`default_nettype wire
